// ----- rtl/core/uft_pkg.sv -----
// uft_pkg: shared types and constants of the uart frame transmitter
// no dependencies; imported by the queue, serializer and top level
package uft_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_BIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP_BIT_COUNT = 1'd1;

  // register widths and reset values
  localparam int TICK_W = 16;
  localparam int STOP_W = 2;
  localparam logic [TICK_W-1:0] TICKS_PER_BIT_RST = 16'd104;
  localparam logic [STOP_W-1:0] STOP_BIT_COUNT_RST = 2'd1;

  // stream payload widths
  localparam int BYTE_W = 8;
  localparam int OUT_DATA_W = 8;

  // one tick request as it travels through the queue
  typedef struct packed {
    logic              send_request;
    logic [BYTE_W-1:0] data_byte;
  } tick_req_t;

  // one result item
  typedef struct packed {
    logic accepted;
    logic busy_res;
    logic line_level;
  } tick_res_t;

  // queue head handed to the serializer
  typedef struct packed {
    logic      valid;
    tick_req_t req;
  } queue_head_t;

endpackage

// ----- rtl/core/uft_tick_queue.sv -----
// uft_tick_queue: front part, takes tick requests and holds them in a two-entry queue
// depends on uft_pkg
module uft_tick_queue
  import uft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  tick_req_t   push_req,
  output queue_head_t head,
  input  logic        pop
);

  tick_req_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  // handshake on both sides
  assign push_ready = (count_r != 2'd2);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && (count_r != 2'd0);

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

  // head of queue
  assign head.valid = (count_r != 2'd0);
  assign head.req   = mem_r[rd_ptr_r];

endmodule

// ----- rtl/core/uft_serializer.sv -----
// uft_serializer: back part, runs the frame shifter once per tick and registers the result
// depends on uft_pkg; holds the configuration registers
module uft_serializer
  import uft_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]      cfg_data,
  input  queue_head_t            head,
  output logic                   pop,
  output logic                   res_valid,
  input  logic                   res_ready,
  output tick_res_t              res
);

  localparam int FRAME_W = DATA_BITS + 3;

  logic [TICK_W-1:0]  tpb_r;
  logic [STOP_W-1:0]  stops_r;
  logic [FRAME_W-1:0] shift_r, shift_nxt;
  logic [3:0]         bits_left_r, bits_left_nxt;
  logic [TICK_W-1:0]  tick_cnt_r, tick_cnt_nxt;
  logic               sending_r, sending_nxt;
  logic               res_valid_r;
  tick_res_t          res_r, res_nxt;
  logic [TICK_W-1:0]  period;
  logic [TICK_W-1:0]  tick_inc;
  logic [3:0]         bits_dec;
  logic [3:0]         frame_len;
  logic [DATA_BITS+BYTE_W-1:0] data_ext;
  logic               take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpb_r   <= TICKS_PER_BIT_RST;
      stops_r <= STOP_BIT_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICKS_PER_BIT:  tpb_r   <= cfg_data;
        CFG_STOP_BIT_COUNT: stops_r <= cfg_data[STOP_W-1:0];
        default:            ;
      endcase
    end
  end

  // a tick is taken when the output register is free or being drained
  assign take = head.valid && (!res_valid_r || res_ready);
  assign pop  = take;

  // bit period, frame length and data bits above bit 7 forced low
  assign period    = (tpb_r == '0) ? TICK_W'(1) : tpb_r;
  assign tick_inc  = tick_cnt_r + TICK_W'(1);
  assign bits_dec  = (bits_left_r == 4'd0) ? 4'd0 : bits_left_r - 4'd1;
  assign frame_len = 4'(DATA_BITS + 1) + (stops_r[1] ? 4'd2 : 4'd1);
  assign data_ext  = {{DATA_BITS{1'b0}}, head.req.data_byte};

  // one tick of the frame shifter
  always_comb begin
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    tick_cnt_nxt  = tick_cnt_r;
    sending_nxt   = sending_r;
    res_nxt.accepted = 1'b0;
    if (sending_r) begin
      tick_cnt_nxt = tick_inc;
      if (tick_inc >= period) begin
        tick_cnt_nxt  = '0;
        shift_nxt     = {1'b1, shift_r[FRAME_W-1:1]};
        bits_left_nxt = bits_dec;
        if (bits_dec == 4'd0) begin
          sending_nxt = 1'b0;
          shift_nxt   = '1;
        end
      end
    end else if (head.req.send_request) begin
      shift_nxt        = {2'b11, data_ext[DATA_BITS-1:0], 1'b0};
      bits_left_nxt    = frame_len;
      tick_cnt_nxt     = '0;
      sending_nxt      = 1'b1;
      res_nxt.accepted = 1'b1;
    end
    res_nxt.line_level = sending_nxt ? shift_nxt[0] : 1'b1;
    res_nxt.busy_res   = sending_nxt;
  end

  // frame state, advanced once per taken tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '1;
      bits_left_r <= 4'd0;
      tick_cnt_r  <= '0;
      sending_r   <= 1'b0;
    end else if (take) begin
      shift_r     <= shift_nxt;
      bits_left_r <= bits_left_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      sending_r   <= sending_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (take) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ----- rtl/core/uart_frame_transmitter.sv -----
// channel  | direction | payload                                         | handshake
// in_      | input     | tdata[7:0] data_byte; tuser[0] send_request     | in_tvalid/in_tready
// out_     | output    | tdata[0] line_level, [1] busy_res, [2] accepted | out_tvalid/out_tready
// cfg_     | input     | cfg_index register, cfg_data value              | cfg_valid/cfg_ready
//
// one tick request per clock and one result per clock when both sides keep up
// a tick request passes through the tick queue register, then the serializer output register
// the serializer updates frame state once per taken tick (one 16-bit add and compare)
// the two-entry queue absorbs output stalls; in_tready drops only when it is full
// rst_n is synchronous and active low; cfg_ready is always high
// depends on uft_pkg, uft_tick_queue, uft_serializer
module uart_frame_transmitter
  import uft_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] send_request
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // [0] line_level, [1] busy_res, [2] accepted, zero fill
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]      cfg_data
);

  tick_req_t   push_req;
  queue_head_t head;
  logic        pop;
  tick_res_t   res;

  assign push_req.send_request = in_tuser;
  assign push_req.data_byte    = in_tdata;
  assign cfg_ready             = 1'b1;

  // front: tick queue
  uft_tick_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_req   (push_req),
    .head       (head),
    .pop        (pop)
  );

  // back: frame serializer
  uft_serializer #(
    .DATA_BITS (DATA_BITS)
  ) u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // pack result fields
  assign out_tdata = {{(OUT_DATA_W-3){1'b0}}, res.accepted, res.busy_res, res.line_level};

endmodule

// ----- rtl/core/uft_checker.sv -----
// uft_checker: port-level checks of the uart frame transmitter, bound to the top level
// depends on uft_pkg and uart_frame_transmitter
module uft_checker
  import uft_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // an accepted byte starts a frame
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1] && !out_tdata[0])
    else $error("accepted without start bit");

  // idle line stays high
  a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[0])
    else $error("line low while idle");

endmodule

bind uart_frame_transmitter uft_checker u_uft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for the uart frame transmitter
// drives clock ticks with optional bytes, predicts line level, busy and accepted flags
// depends on uft_pkg and uart_frame_transmitter
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import uft_pkg::*;

  localparam int DATA_BITS   = 8;
  localparam int FRAME_W     = 1 + DATA_BITS + 2;
  localparam int NUM_PHASES  = 8;
  localparam int IDLE_PCT    = 23;
  localparam int REQUEST_PCT = 70;
  localparam int DRAIN_TICKS = 6;

  // line predictor plus queue of expected per-tick results
  class line_scoreboard;
    logic [TICK_W-1:0]  bit_ticks;
    logic [STOP_W-1:0]  stop_setting;
    logic [FRAME_W-1:0] frame_bits;
    logic [3:0]         bits_left;
    logic [TICK_W-1:0]  held_ticks;
    bit                 sending;
    tick_res_t          pending_levels[$];
    int                 errors;
    int                 ticks_noted;
    int                 bytes_taken;
    int                 results_checked;

    function new();
      bit_ticks       = TICKS_PER_BIT_RST;
      stop_setting    = STOP_BIT_COUNT_RST;
      frame_bits      = '1;
      bits_left       = '0;
      held_ticks      = '0;
      sending         = 1'b0;
      errors          = 0;
      ticks_noted     = 0;
      bytes_taken     = 0;
      results_checked = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [TICK_W-1:0] value);
      case (idx)
        CFG_TICKS_PER_BIT: begin
          bit_ticks = value;
        end
        CFG_STOP_BIT_COUNT: begin
          stop_setting = value[STOP_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // advance the frame by one tick and queue the resulting line state
    function void note_tick(logic req, logic [BYTE_W-1:0] data);
      logic [TICK_W:0] period;
      tick_res_t       res;
      period       = (bit_ticks == '0) ? (TICK_W+1)'(1) : {1'b0, bit_ticks};
      res.accepted = 1'b0;
      if (sending) begin
        held_ticks = held_ticks + 1'b1;
        // bit ends once its hold count reaches the current period
        if ({1'b0, held_ticks} >= period) begin
          held_ticks = '0;
          frame_bits = {1'b1, frame_bits[FRAME_W-1:1]};
          if (bits_left != '0) bits_left = bits_left - 1'b1;
          if (bits_left == '0) begin
            sending    = 1'b0;
            frame_bits = '1;
          end
        end
      end else if (req) begin
        // start bit low, data lsb first, stop bits high on top
        frame_bits   = {2'b11, data, 1'b0};
        bits_left    = (stop_setting >= 2) ? 4'd11 : 4'd10;
        held_ticks   = '0;
        sending      = 1'b1;
        res.accepted = 1'b1;
        bytes_taken++;
      end
      res.line_level = sending ? frame_bits[0] : 1'b1;
      res.busy_res   = sending;
      pending_levels.push_back(res);
      ticks_noted++;
    endfunction

    // compare one result against the oldest prediction
    function void check_result(logic [OUT_DATA_W-1:0] tdata);
      tick_res_t want;
      if (pending_levels.size() == 0) begin
        $error("result with no tick waiting: tdata %0h", tdata);
        errors++;
        return;
      end
      want = pending_levels.pop_front();
      results_checked++;
      if (tdata[0] !== want.line_level) begin
        $error("line_level: expected %0b, got %0b", want.line_level, tdata[0]);
        errors++;
      end
      if (tdata[1] !== want.busy_res) begin
        $error("busy_res: expected %0b, got %0b", want.busy_res, tdata[1]);
        errors++;
      end
      if (tdata[2] !== want.accepted) begin
        $error("accepted: expected %0b, got %0b", want.accepted, tdata[2]);
        errors++;
      end
    endfunction

    function int waiting();
      return pending_levels.size();
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata   = '0;   // [7:0] data_byte
  logic                   in_tuser   = 1'b0; // [0] send_request
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;         // [0] line_level, [1] busy_res, [2] accepted
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = CFG_TICKS_PER_BIT;
  logic [TICK_W-1:0]      cfg_data   = '0;

  bit             steady = 1'b0;
  int             settings_used = 0;
  line_scoreboard sb = new();

  // phase settings: period extremes and every stop count encoding
  logic [TICK_W-1:0] phase_ticks [NUM_PHASES] = '{16'd1, 16'd2, 16'd65535, 16'd3,
                                                  16'd1, 16'd6, 16'd0, 16'd4};
  logic [STOP_W-1:0] phase_stops [NUM_PHASES] = '{2'd1, 2'd0, 2'd1, 2'd2,
                                                  2'd3, 2'd2, 2'd1, 2'd0};
  int                phase_len   [NUM_PHASES] = '{80, 80, 30, 80, 80, 80, 80, 80};

  uart_frame_transmitter #(.DATA_BITS(DATA_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // result side backpressure
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // result monitor: sampled mid-cycle, taken at the following edge
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // one tick request, with random idle cycles ahead of it
  task automatic drive_tick(input logic req, input logic [BYTE_W-1:0] data);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= data;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    sb.note_tick(req, data);
  endtask

  // stop ticking and wait until every result is out
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
  endtask

  // write both registers; stop count goes with random upper bits
  task automatic write_settings(input logic [TICK_W-1:0] ticks,
                                input logic [STOP_W-1:0] stops);
    logic [TICK_W-1:0] stop_word;
    stop_word              = TICK_W'($urandom);
    stop_word[STOP_W-1:0]  = stops;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TICKS_PER_BIT;
    cfg_data  <= ticks;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    sb.set_register(CFG_TICKS_PER_BIT, ticks);
    cfg_index <= CFG_STOP_BIT_COUNT;
    cfg_data  <= stop_word;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    sb.set_register(CFG_STOP_BIT_COUNT, stop_word);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // main sequence
  initial begin
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: idle tick, byte taken, requests while busy ignored
    drive_tick(1'b0, 8'hFF);
    drive_tick(1'b1, 8'h00);
    drive_tick(1'b1, 8'hFF);
    drive_tick(1'b0, 8'h55);
    drive_tick(1'b1, 8'h80);
    drive_tick(1'b1, 8'h01);
    drive_tick(1'b0, 8'h00);
    drive_tick(1'b1, 8'hAA);
    settle();

    // zero period mid-frame, stop count three; frame ends then next byte goes
    write_settings(16'd0, 2'd3);
    repeat (17) drive_tick(1'b1, 8'hFF);

    // random ticks under several settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      steady = (p == 1);
      write_settings(phase_ticks[p], phase_stops[p]);
      repeat (phase_len[p]) drive_tick($urandom_range(99) < REQUEST_PCT, BYTE_W'($urandom));
    end
    steady = 1'b0;
    settle();

    $display("covered %0d ticks and %0d framed bytes over %0d register settings",
             sb.ticks_noted, sb.bytes_taken, settings_used);
    $display("checked %0d results, %0d mismatches", sb.results_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #3_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
